FILE: src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, codes and fixed-point helpers for the LSTM cell step block.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int FEATURES     = 5;
  localparam int NUM_GATES    = 4;
  localparam int DATA_W       = 16;
  localparam int ACC_W        = 48;
  // MAC pipeline depth from last issue to activation write, plus margin
  localparam int DRAIN_CYCLES = 7;

  localparam logic [1:0] OP_LOAD_W = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  localparam logic [1:0] GATE_FORGET = 2'd0;
  localparam logic [1:0] GATE_INPUT  = 2'd1;
  localparam logic [1:0] GATE_CAND   = 2'd2;
  localparam logic [1:0] GATE_OUTPUT = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic wr_w;
    logic wr_b;
  } ld_ctl_t;

  // round half up to frac fraction bits, then saturate to 16 bits
  function automatic data_t round_sat(input logic signed [ACC_W-1:0] v,
                                      input int unsigned frac);
    logic signed [ACC_W-1:0] t;
    t = (v + (ACC_W'(1) <<< (frac - 1))) >>> frac;
    if (t > 48'sd32767) begin
      return 16'sh7fff;
    end else if (t < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return t[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: src/lcs_in_if.sv
// ----------------------------------------------------------------------------
// lcs_in_if
// Input channel: load and step items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [1:0]        gate;
  logic [6:0]        row;
  logic [5:0]        column;
  lcs_pkg::data_t    coefficient;
  lcs_pkg::data_t    feature_date;
  lcs_pkg::data_t    feature_temperature;
  lcs_pkg::data_t    feature_humidity;
  lcs_pkg::data_t    feature_wind;
  lcs_pkg::data_t    feature_pressure;

  modport source (
    output valid, op, gate, row, column, coefficient, feature_date,
           feature_temperature, feature_humidity, feature_wind, feature_pressure,
    input  ready
  );
  modport sink (
    input  valid, op, gate, row, column, coefficient, feature_date,
           feature_temperature, feature_humidity, feature_wind, feature_pressure,
    output ready
  );
endinterface

FILE: src/lcs_out_if.sv
// ----------------------------------------------------------------------------
// lcs_out_if
// Result channel: one hidden/cell value per unit with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         unit;
  logic signed [13:0] hidden_value;
  lcs_pkg::data_t     cell_value;
  logic               last;

  modport source (
    output valid, unit, hidden_value, cell_value, last,
    input  ready
  );
  modport sink (
    input  valid, unit, hidden_value, cell_value, last,
    output ready
  );
endinterface

FILE: src/lcs_act_lut.sv
// ----------------------------------------------------------------------------
// lcs_act_lut
// Saturating sigmoid or tanh lookup; table built at elaboration.
// ----------------------------------------------------------------------------
module lcs_act_lut #(
  parameter int FRACTION_BITS   = 12,
  parameter int ACT_TABLE_DEPTH = 256,
  parameter bit IS_TANH         = 1'b0
) (
  input  logic           clk,
  input  lcs_pkg::data_t a,
  output lcs_pkg::data_t val
);

  localparam int IDX_W  = $clog2(ACT_TABLE_DEPTH);
  localparam int PROD_W = 16 + $clog2(ACT_TABLE_DEPTH + 1);
  localparam longint Q30   = 64'sd1 <<< 30;
  localparam longint ONE_Q = 64'sd1 <<< FRACTION_BITS;

  typedef lcs_pkg::data_t tab_t [ACT_TABLE_DEPTH];

  // shift-subtract quotient, both operands nonnegative
  function automatic longint udiv(input longint n, input longint d);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((n >>> b) & 64'sd1);
      q   = q <<< 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // exp(-r), r and result in Q30, r in [0, 1]
  function automatic longint exp_frac(input longint r);
    longint sum;
    longint term;
    sum  = Q30;
    term = Q30;
    for (int k = 1; k <= 18; k++) begin
      term = udiv((term * r) >>> 30, longint'(k));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  function automatic longint exp_neg(input longint mag);
    longint e1;
    longint n;
    longint r;
    longint res;
    e1  = exp_frac(Q30);
    n   = mag >>> FRACTION_BITS;
    r   = (mag & (ONE_Q - 1)) <<< (30 - FRACTION_BITS);
    res = exp_frac(r);
    for (longint i = 0; i < n && res > 0; i++) begin
      res = (res * e1 + (64'sd1 <<< 29)) >>> 30;
    end
    return res;
  endfunction

  function automatic tab_t build_tab();
    tab_t   tab;
    longint mid;
    longint mag;
    longint e;
    longint e2;
    longint den;
    longint num;
    longint t;
    for (int k = 0; k < ACT_TABLE_DEPTH; k++) begin
      mid = udiv((2 * longint'(k) + 1) * 65536, 2 * longint'(ACT_TABLE_DEPTH)) - 32768;
      mag = (mid < 0) ? -mid : mid;
      if (IS_TANH) begin
        e2  = exp_neg(2 * mag);
        den = Q30 + e2;
        t   = udiv(((Q30 - e2) <<< FRACTION_BITS) + (den >>> 1), den);
        tab[k] = 16'((mid < 0) ? -t : t);
      end else begin
        e   = exp_neg(mag);
        den = Q30 + e;
        num = (mid >= 0) ? (Q30 <<< FRACTION_BITS) : (e <<< FRACTION_BITS);
        tab[k] = 16'(udiv(num + (den >>> 1), den));
      end
    end
    return tab;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [15:0]       a_ofs;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx_r;

  // offset binary, then scale into bins
  assign a_ofs = {~a[15], a[14:0]};
  assign prod  = PROD_W'(a_ofs) * PROD_W'(ACT_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    idx_r <= IDX_W'(prod >> 16);
  end

  assign val = TAB[idx_r];

endmodule

FILE: src/lcs_mac_lane.sv
// ----------------------------------------------------------------------------
// lcs_mac_lane
// One gate lane: weight/bias store, MAC, activation and per-unit result store.
// ----------------------------------------------------------------------------
module lcs_mac_lane #(
  parameter int HIDDEN_UNITS    = 8,
  parameter int FRACTION_BITS   = 12,
  parameter int ACT_TABLE_DEPTH = 256,
  parameter bit IS_TANH         = 1'b0,
  localparam int ROWS    = lcs_pkg::FEATURES + HIDDEN_UNITS,
  localparam int W_DEPTH = ROWS * HIDDEN_UNITS,
  localparam int WA_W    = $clog2(W_DEPTH),
  localparam int U_W     = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lcs_pkg::ld_ctl_t  ld,
  input  logic [WA_W-1:0]   ld_waddr,
  input  logic [U_W-1:0]    ld_baddr,
  input  lcs_pkg::data_t    ld_coef,
  input  lcs_pkg::mac_ctl_t issue,
  input  logic [WA_W-1:0]   rd_waddr,
  input  logic [U_W-1:0]    rd_u,
  input  lcs_pkg::data_t    x_val,
  input  logic [U_W-1:0]    act_raddr,
  output lcs_pkg::data_t    act_rdata
);

  localparam int ACC_W = lcs_pkg::ACC_W;

  lcs_pkg::data_t w_mem   [W_DEPTH];
  lcs_pkg::data_t b_mem   [HIDDEN_UNITS];
  lcs_pkg::data_t act_mem [HIDDEN_UNITS];

  lcs_pkg::data_t    w_q;
  lcs_pkg::data_t    b_q;
  lcs_pkg::data_t    b2_r;
  lcs_pkg::mac_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic [U_W-1:0]    u1_r, u2_r, u3_r, u4_r, act_u_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  lcs_pkg::data_t    a_r;
  logic              a_vld_r;
  logic              act_we_r;
  lcs_pkg::data_t    act_val;

  always_ff @(posedge clk) begin
    if (ld.wr_w) w_mem[ld_waddr] <= ld_coef;
    w_q <= w_mem[rd_waddr];
  end

  always_ff @(posedge clk) begin
    if (ld.wr_b) b_mem[ld_baddr] <= ld_coef;
    b_q <= b_mem[rd_u];
  end

  always_ff @(posedge clk) begin
    if (act_we_r) act_mem[act_u_r] <= act_val;
    act_rdata <= act_mem[act_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r   <= '0;
      ctl2_r   <= '0;
      ctl3_r   <= '0;
      a_vld_r  <= 1'b0;
      act_we_r <= 1'b0;
    end else begin
      ctl1_r   <= issue;
      ctl2_r   <= ctl1_r;
      ctl3_r   <= ctl2_r;
      a_vld_r  <= ctl3_r.vld && ctl3_r.last;
      act_we_r <= a_vld_r;
    end
  end

  // bias enters scaled to the product fraction width on the first row
  always_comb begin
    if (ctl2_r.first) begin
      acc_nxt = (ACC_W'(b2_r) <<< FRACTION_BITS) + ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    u1_r    <= rd_u;
    u2_r    <= u1_r;
    u3_r    <= u2_r;
    u4_r    <= u3_r;
    act_u_r <= u4_r;
    prod_r  <= 32'(x_val) * 32'(w_q);
    b2_r    <= b_q;
    if (ctl2_r.vld) acc_r <= acc_nxt;
    a_r     <= lcs_pkg::round_sat(acc_r, FRACTION_BITS);
  end

  lcs_act_lut #(
    .FRACTION_BITS  (FRACTION_BITS),
    .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH),
    .IS_TANH        (IS_TANH)
  ) u_lut (
    .clk(clk),
    .a  (a_r),
    .val(act_val)
  );

endmodule

FILE: src/lcs_merge.sv
// ----------------------------------------------------------------------------
// lcs_merge
// Combines the four gate activations per unit: cell and hidden update, output.
// ----------------------------------------------------------------------------
module lcs_merge #(
  parameter int HIDDEN_UNITS    = 8,
  parameter int FRACTION_BITS   = 12,
  parameter int ACT_TABLE_DEPTH = 256,
  localparam int U_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            done,
  input  logic [U_W-1:0]  hid_raddr,
  output lcs_pkg::data_t  hid_rdata,
  output logic [U_W-1:0]  act_raddr,
  input  lcs_pkg::data_t  act_f,
  input  lcs_pkg::data_t  act_i,
  input  lcs_pkg::data_t  act_g,
  input  lcs_pkg::data_t  act_o,
  lcs_out_if.source       out_ch
);

  localparam int ACC_W = lcs_pkg::ACC_W;

  typedef enum logic [3:0] {
    M_IDLE, M_RD, M_MUL, M_SUM, M_IDX, M_TH, M_MUL2, M_HID, M_OUT
  } mst_t;

  mst_t st_r;
  logic [U_W-1:0] u_r;
  logic           out_valid_r;
  logic           done_r;
  logic [5:0]     unit_r;
  logic signed [13:0] hid_out_r;
  lcs_pkg::data_t cell_out_r;
  logic           last_r;

  lcs_pkg::data_t hid_mem  [HIDDEN_UNITS];
  lcs_pkg::data_t cell_mem [HIDDEN_UNITS];
  logic [HIDDEN_UNITS-1:0] vld_r;
  lcs_pkg::data_t hid_q, cell_q, cell_rd;
  logic           hid_vq, cell_vq;

  logic signed [31:0] p1_r, p2_r, p3_r;
  lcs_pkg::data_t cn_r, t_r, hn, tanh_val;
  logic           wr_en;

  assign wr_en     = (st_r == M_HID);
  assign act_raddr = u_r;
  assign hn        = lcs_pkg::round_sat(ACC_W'(p3_r), FRACTION_BITS);
  assign hid_rdata = hid_vq ? hid_q : '0;
  assign cell_rd   = cell_vq ? cell_q : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hid_mem[u_r]  <= hn;
      cell_mem[u_r] <= cn_r;
    end
    hid_q   <= hid_mem[hid_raddr];
    hid_vq  <= vld_r[hid_raddr];
    cell_q  <= cell_mem[u_r];
    cell_vq <= vld_r[u_r];
  end

  // unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[u_r] <= 1'b1;
    end
  end

  lcs_act_lut #(
    .FRACTION_BITS  (FRACTION_BITS),
    .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH),
    .IS_TANH        (1'b1)
  ) u_tanh (
    .clk(clk),
    .a  (cn_r),
    .val(tanh_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= M_IDLE;
      u_r         <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        M_IDLE: begin
          if (start) begin
            u_r  <= '0;
            st_r <= M_RD;
          end
        end
        M_RD: st_r <= M_MUL;
        M_MUL: begin
          p1_r <= 32'(act_f) * 32'(cell_rd);
          p2_r <= 32'(act_i) * 32'(act_g);
          st_r <= M_SUM;
        end
        M_SUM: begin
          cn_r <= lcs_pkg::round_sat(ACC_W'(p1_r) + ACC_W'(p2_r), FRACTION_BITS);
          st_r <= M_IDX;
        end
        M_IDX: st_r <= M_TH;  // lut latches its index from cn_r
        M_TH: begin
          t_r  <= tanh_val;
          st_r <= M_MUL2;
        end
        M_MUL2: begin
          p3_r <= 32'(act_o) * 32'(t_r);
          st_r <= M_HID;
        end
        M_HID: begin
          unit_r <= 6'(u_r);
          if (hn > 16'sd8191) begin
            hid_out_r <= 14'sd8191;
          end else if (hn < -16'sd8192) begin
            hid_out_r <= -14'sd8192;
          end else begin
            hid_out_r <= hn[13:0];
          end
          cell_out_r  <= cn_r;
          last_r      <= (u_r == U_W'(HIDDEN_UNITS - 1));
          out_valid_r <= 1'b1;
          st_r        <= M_OUT;
        end
        M_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (u_r == U_W'(HIDDEN_UNITS - 1)) begin
              done_r <= 1'b1;
              st_r   <= M_IDLE;
            end else begin
              u_r  <= u_r + 1'b1;
              st_r <= M_RD;
            end
          end
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign done                = done_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.unit         = unit_r;
  assign out_ch.hidden_value = hid_out_r;
  assign out_ch.cell_value   = cell_out_r;
  assign out_ch.last         = last_r;

endmodule

FILE: src/lstm_cell_step_top.sv
// ----------------------------------------------------------------------------
// lstm_cell_step_top
// LSTM cell step: four gate MAC lanes plus a merging cell/hidden update stage.
// ----------------------------------------------------------------------------
// Load items: accepted whenever the block is idle, no result.
// Step items: after the accept, a MAC issue phase over every weight, a drain
// phase, then the update sequencer for each unit in turn, a done pulse and any
// output stall. One item in flight: no new item is taken until the update ends.
// Synchronous active-low reset clears control, hidden and cell state; weights
// and biases keep no reset and must be loaded before use.
module lstm_cell_step_top #(
  parameter int HIDDEN_UNITS    = 8,
  parameter int FRACTION_BITS   = 12,
  parameter int ACT_TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  lcs_in_if.sink     in_ch,
  lcs_out_if.source  out_ch
);

  localparam int ROWS    = lcs_pkg::FEATURES + HIDDEN_UNITS;
  localparam int W_DEPTH = ROWS * HIDDEN_UNITS;
  localparam int WA_W    = $clog2(W_DEPTH);
  localparam int U_W     = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int J_W     = $clog2(ROWS);
  localparam int F_W     = $clog2(lcs_pkg::FEATURES);
  localparam int DR_W    = $clog2(lcs_pkg::DRAIN_CYCLES);

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_UPD} st_t;

  st_t             st_r;
  logic [J_W-1:0]  j_r;
  logic [U_W-1:0]  u_r;
  logic [WA_W-1:0] addr_r;
  logic [DR_W-1:0] dcnt_r;
  lcs_pkg::data_t  feat_r [lcs_pkg::FEATURES];
  lcs_pkg::data_t  xf_r;
  logic            xsel_r;

  logic              accept;
  logic              wr_w_ok, wr_b_ok;
  logic [13:0]       lin;
  logic [WA_W-1:0]   ld_waddr;
  logic [U_W-1:0]    ld_baddr;
  lcs_pkg::ld_ctl_t  ld [lcs_pkg::NUM_GATES];
  lcs_pkg::mac_ctl_t issue;
  logic [U_W-1:0]    hid_raddr;
  lcs_pkg::data_t    hid_rdata;
  lcs_pkg::data_t    x_val;
  logic [U_W-1:0]    act_raddr;
  lcs_pkg::data_t    act_data [lcs_pkg::NUM_GATES];
  logic              upd_start, upd_done;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // out-of-range load addresses are dropped
  assign wr_w_ok = accept && (in_ch.op == lcs_pkg::OP_LOAD_W) &&
                   (in_ch.row < ROWS) && (in_ch.column < HIDDEN_UNITS);
  assign wr_b_ok = accept && (in_ch.op == lcs_pkg::OP_LOAD_B) &&
                   (in_ch.column < HIDDEN_UNITS);
  assign lin      = 14'(in_ch.row) * 14'(HIDDEN_UNITS) + 14'(in_ch.column);
  assign ld_waddr = WA_W'(lin);
  assign ld_baddr = U_W'(in_ch.column);

  assign issue.vld   = (st_r == ST_MAC);
  assign issue.first = (j_r == '0);
  assign issue.last  = (j_r == J_W'(ROWS - 1));

  assign hid_raddr = (j_r >= J_W'(lcs_pkg::FEATURES)) ?
                     U_W'(j_r - J_W'(lcs_pkg::FEATURES)) : '0;
  assign x_val     = xsel_r ? xf_r : hid_rdata;
  assign upd_start = (st_r == ST_DRAIN) && (dcnt_r == DR_W'(lcs_pkg::DRAIN_CYCLES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      j_r    <= '0;
      u_r    <= '0;
      addr_r <= '0;
      dcnt_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (accept && in_ch.op == lcs_pkg::OP_STEP) begin
            feat_r[0] <= in_ch.feature_date;
            feat_r[1] <= in_ch.feature_temperature;
            feat_r[2] <= in_ch.feature_humidity;
            feat_r[3] <= in_ch.feature_wind;
            feat_r[4] <= in_ch.feature_pressure;
            j_r    <= '0;
            u_r    <= '0;
            addr_r <= '0;
            st_r   <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (j_r == J_W'(ROWS - 1)) begin
            j_r <= '0;
            if (u_r == U_W'(HIDDEN_UNITS - 1)) begin
              u_r    <= '0;
              addr_r <= '0;
              dcnt_r <= '0;
              st_r   <= ST_DRAIN;
            end else begin
              u_r    <= u_r + 1'b1;
              addr_r <= WA_W'(u_r) + 1'b1;
            end
          end else begin
            j_r    <= j_r + 1'b1;
            addr_r <= addr_r + WA_W'(HIDDEN_UNITS);
          end
        end
        ST_DRAIN: begin
          if (upd_start) st_r <= ST_UPD;
          else           dcnt_r <= dcnt_r + 1'b1;
        end
        ST_UPD: begin
          if (upd_done) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // operand select, aligned with the registered hidden read
  always_ff @(posedge clk) begin
    xsel_r <= (j_r < J_W'(lcs_pkg::FEATURES));
    xf_r   <= (j_r < J_W'(lcs_pkg::FEATURES)) ? feat_r[F_W'(j_r)] : '0;
  end

  for (genvar g = 0; g < lcs_pkg::NUM_GATES; g++) begin : g_lane
    assign ld[g].wr_w = wr_w_ok && (in_ch.gate == 2'(g));
    assign ld[g].wr_b = wr_b_ok && (in_ch.gate == 2'(g));

    lcs_mac_lane #(
      .HIDDEN_UNITS   (HIDDEN_UNITS),
      .FRACTION_BITS  (FRACTION_BITS),
      .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH),
      .IS_TANH        (g == int'(lcs_pkg::GATE_CAND))
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ld       (ld[g]),
      .ld_waddr (ld_waddr),
      .ld_baddr (ld_baddr),
      .ld_coef  (in_ch.coefficient),
      .issue    (issue),
      .rd_waddr (addr_r),
      .rd_u     (u_r),
      .x_val    (x_val),
      .act_raddr(act_raddr),
      .act_rdata(act_data[g])
    );
  end

  lcs_merge #(
    .HIDDEN_UNITS   (HIDDEN_UNITS),
    .FRACTION_BITS  (FRACTION_BITS),
    .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (upd_start),
    .done     (upd_done),
    .hid_raddr(hid_raddr),
    .hid_rdata(hid_rdata),
    .act_raddr(act_raddr),
    .act_f    (act_data[lcs_pkg::GATE_FORGET]),
    .act_i    (act_data[lcs_pkg::GATE_INPUT]),
    .act_g    (act_data[lcs_pkg::GATE_CAND]),
    .act_o    (act_data[lcs_pkg::GATE_OUTPUT]),
    .out_ch   (out_ch)
  );

  a_no_out_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MAC) |-> !out_ch.valid)
    else $error("result transfer offered while MAC phase running");

  a_done_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
    upd_done |-> (st_r == ST_UPD))
    else $error("update done outside update phase");

  a_mac_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.vld && issue.last && u_r == U_W'(HIDDEN_UNITS - 1)) |=> (st_r == ST_DRAIN))
    else $error("final MAC issue not followed by drain");

endmodule
